[rtl/mavg_pkg.sv]
// package for the moving average filter: sizes, register map and sequencer states
// no dependencies
package mavg_pkg;

    // default sizing, handed to the top level parameters
    localparam int MAX_WINDOW_DEF  = 64;
    localparam int SAMPLE_BITS_DEF = 16;

    // window length register width, fixed by the register map
    localparam int CFG_LEN_W = 7;

    // config port sizing
    localparam int PADDR_W = 3;
    localparam int PDATA_W = 32;

    // register index, taken from paddr[2]
    localparam logic REG_WINDOW_LENGTH = 1'b0;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_READ,
        ST_LOAD,
        ST_DIV,
        ST_DONE
    } state_t;

endpackage

[rtl/moving_average_filter.sv]
// moving average filter top level: ring buffer memory, running sum and serial divider
// depends on mavg_pkg
//
// Boxcar moving average over a window of up to MAX_WINDOW signed samples (the window
// length register holds 0..127 and saturates at MAX_WINDOW). Every accepted sample beat
// yields exactly one average beat, the window sum divided by the window length and
// truncated toward zero. A length of 0 or 1 passes the sample straight through and leaves
// the filter state alone. The first sample after reset or after a window length write
// primes the filter as if the whole window held that sample; no fill or clearing pass is
// made, slots not yet written since priming read as the priming sample. One item is worked
// on at a time. A pass-through sample goes from accept straight to the done state. A
// priming sample goes from accept to the divider; any later sample first has the history
// memory read, then the read-modify-write of the running sum, then the restoring divider,
// which produces one quotient bit per cycle over the SAMPLE_BITS + 7 bit sum. The finished
// average sits in an output register, so the next sample is taken while the previous
// result waits. The window length register is written and read over the APB port at
// byte address 0; the user must write it only while the block is idle, as the block
// itself does not enforce this.
module moving_average_filter #(
    parameter int MAX_WINDOW  = mavg_pkg::MAX_WINDOW_DEF,
    parameter int SAMPLE_BITS = mavg_pkg::SAMPLE_BITS_DEF
) (
    input  logic                          aclk,
    input  logic                          aresetn,
    // sample input channel
    input  logic                          s_valid,
    output logic                          s_ready,
    input  logic signed [SAMPLE_BITS-1:0] s_sample,
    // average output channel
    output logic                          m_valid,
    input  logic                          m_ready,
    output logic signed [SAMPLE_BITS-1:0] m_average,
    // config port
    input  logic                          psel,
    input  logic                          penable,
    input  logic                          pwrite,
    input  logic [mavg_pkg::PADDR_W-1:0]  paddr,
    input  logic [mavg_pkg::PDATA_W-1:0]  pwdata,
    output logic [mavg_pkg::PDATA_W-1:0]  prdata,
    output logic                          pready
);
    import mavg_pkg::*;

    // ring buffer index width and a width that holds both an index + 1 and a length
    localparam int IDX_W = $clog2(MAX_WINDOW);
    localparam int CMP_W = (IDX_W + 1 > CFG_LEN_W) ? IDX_W + 1 : CFG_LEN_W;
    // running sum: up to 127 samples
    localparam int SUM_W = SAMPLE_BITS + CFG_LEN_W;
    localparam int CNT_W = $clog2(SUM_W);

    // sequencer
    state_t state_reg, state_next;

    // config and filter state
    logic [CFG_LEN_W-1:0]          len_reg;
    logic signed [SUM_W-1:0]       sum_reg;
    logic [IDX_W-1:0]              idx_reg;
    logic                          primed_reg;
    logic                          full_reg;     // every window slot written since priming
    logic signed [SAMPLE_BITS-1:0] prime_reg;
    logic signed [SAMPLE_BITS-1:0] sample_reg;

    // history memory with a registered read
    logic signed [SAMPLE_BITS-1:0] hist_mem [MAX_WINDOW];
    logic signed [SAMPLE_BITS-1:0] hist_rdata_reg;

    // divider
    logic [SUM_W-1:0]              mag_reg;      // dividend magnitude, then quotient
    logic [CFG_LEN_W-1:0]          rem_reg;
    logic                          neg_reg;
    logic [CNT_W-1:0]              cnt_reg;

    // output register
    logic                          m_valid_reg;
    logic signed [SAMPLE_BITS-1:0] m_average_reg;

    // control from the sequencer
    logic s_accept;
    logic pass_thru;
    logic mem_rd_en;
    logic mem_wr_en;
    logic out_load;
    logic div_last;

    // config write decode
    logic                 cfg_wr;
    logic [CFG_LEN_W-1:0] cfg_len;

    // datapath
    logic signed [SUM_W:0]         prime_prod;
    logic signed [SAMPLE_BITS-1:0] oldest;
    logic signed [SUM_W-1:0]       sum_upd;
    logic [CMP_W-1:0]              idx_inc;
    logic                          idx_wrap;
    logic [CFG_LEN_W:0]            div_shift;
    logic [CFG_LEN_W:0]            div_diff;
    logic                          div_ge;
    logic [SUM_W-1:0]              quot_signed;

    assign pready    = 1'b1;
    assign m_valid   = m_valid_reg;
    assign m_average = m_average_reg;

    // ---------------------------------------------------------------- config port
    assign cfg_wr = psel && penable && pwrite && (paddr[2] == REG_WINDOW_LENGTH);

    // lengths beyond the buffer saturate at its depth
    always_comb begin
        if (CMP_W'(pwdata[CFG_LEN_W-1:0]) > CMP_W'(MAX_WINDOW)) begin
            cfg_len = CFG_LEN_W'(MAX_WINDOW);
        end else begin
            cfg_len = pwdata[CFG_LEN_W-1:0];
        end
    end

    always_comb begin
        if (paddr[2] == REG_WINDOW_LENGTH) begin
            prdata = PDATA_W'(len_reg);
        end else begin
            prdata = '0;
        end
    end

    // ---------------------------------------------------------------- sequencer
    assign s_accept  = s_valid && s_ready;
    assign pass_thru = (len_reg[CFG_LEN_W-1:1] == '0);
    assign div_last  = (cnt_reg == CNT_W'(SUM_W - 1));

    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE: begin
                if (s_valid) begin
                    if (pass_thru) begin
                        state_next = ST_DONE;
                    end else if (primed_reg) begin
                        state_next = ST_READ;
                    end else begin
                        state_next = ST_LOAD;
                    end
                end
            end
            ST_READ: begin
                state_next = ST_LOAD;
            end
            ST_LOAD: begin
                state_next = ST_DIV;
            end
            ST_DIV: begin
                if (div_last) begin
                    state_next = ST_DONE;
                end
            end
            ST_DONE: begin
                if (!m_valid_reg || m_ready) begin
                    state_next = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_comb begin
        s_ready   = 1'b0;
        mem_rd_en = 1'b0;
        mem_wr_en = 1'b0;
        out_load  = 1'b0;
        unique case (state_reg)
            ST_IDLE: begin
                s_ready   = 1'b1;
                mem_rd_en = s_valid && !pass_thru && primed_reg;
            end
            ST_READ: begin
                mem_wr_en = 1'b1;
            end
            ST_LOAD, ST_DIV: begin
            end
            ST_DONE: begin
                out_load = !m_valid_reg || m_ready;
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    // ---------------------------------------------------------------- history memory
    always_ff @(posedge aclk) begin
        if (mem_rd_en) begin
            hist_rdata_reg <= hist_mem[idx_reg];
        end
    end

    always_ff @(posedge aclk) begin
        if (mem_wr_en) begin
            hist_mem[idx_reg] <= sample_reg;
        end
    end

    // ---------------------------------------------------------------- running sum update
    // priming: the whole window holds the sample
    assign prime_prod = s_sample * $signed({1'b0, len_reg});

    // slots not yet written since priming still hold the priming sample
    assign oldest  = full_reg ? hist_rdata_reg : prime_reg;
    assign sum_upd = sum_reg - SUM_W'(oldest) + SUM_W'(sample_reg);

    assign idx_inc  = CMP_W'(idx_reg) + CMP_W'(1);
    assign idx_wrap = (idx_inc >= CMP_W'(len_reg));

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            len_reg    <= CFG_LEN_W'(1);
            sum_reg    <= '0;
            idx_reg    <= '0;
            primed_reg <= 1'b0;
            full_reg   <= 1'b0;
            prime_reg  <= '0;
        end else if (cfg_wr) begin
            // new window length restarts priming
            len_reg    <= cfg_len;
            sum_reg    <= '0;
            idx_reg    <= '0;
            primed_reg <= 1'b0;
            full_reg   <= 1'b0;
            prime_reg  <= '0;
        end else if (s_accept && !pass_thru && !primed_reg) begin
            sum_reg    <= prime_prod[SUM_W-1:0];
            idx_reg    <= '0;
            primed_reg <= 1'b1;
            full_reg   <= 1'b0;
            prime_reg  <= s_sample;
        end else if (mem_wr_en) begin
            sum_reg <= sum_upd;
            if (idx_wrap) begin
                idx_reg  <= '0;
                full_reg <= 1'b1;
            end else begin
                idx_reg <= idx_inc[IDX_W-1:0];
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (s_accept) begin
            sample_reg <= s_sample;
        end
    end

    // ---------------------------------------------------------------- serial divider
    // restoring division of |sum| by the window length, one quotient bit per cycle
    assign div_shift = {rem_reg, mag_reg[SUM_W-1]};
    assign div_ge    = (div_shift >= {1'b0, len_reg});
    assign div_diff  = div_shift - {1'b0, len_reg};

    always_ff @(posedge aclk) begin
        if (s_accept && pass_thru) begin
            // pass through rides the quotient register to the output
            mag_reg <= SUM_W'(s_sample);
            neg_reg <= 1'b0;
        end else if (state_reg == ST_LOAD) begin
            mag_reg <= sum_reg[SUM_W-1] ? SUM_W'(-sum_reg) : SUM_W'(sum_reg);
            neg_reg <= sum_reg[SUM_W-1];
            rem_reg <= '0;
            cnt_reg <= '0;
        end else if (state_reg == ST_DIV) begin
            mag_reg <= {mag_reg[SUM_W-2:0], div_ge};
            rem_reg <= div_ge ? div_diff[CFG_LEN_W-1:0] : div_shift[CFG_LEN_W-1:0];
            cnt_reg <= cnt_reg + CNT_W'(1);
        end
    end

    // truncation toward zero: negate the magnitude quotient
    assign quot_signed = neg_reg ? (~mag_reg + SUM_W'(1)) : mag_reg;

    // ---------------------------------------------------------------- output register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (out_load) begin
            m_valid_reg <= 1'b1;
        end else if (m_ready) begin
            m_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (out_load) begin
            m_average_reg <= quot_signed[SAMPLE_BITS-1:0];
        end
    end

`ifndef SYNTHESIS
    // ring index stays inside the window once primed
    assert property (@(posedge aclk) disable iff (!aresetn)
        (primed_reg && !pass_thru) |-> (CMP_W'(idx_reg) < CMP_W'(len_reg)))
        else $error("write index outside the window");

    // history is only written after priming
    assert property (@(posedge aclk) disable iff (!aresetn)
        mem_wr_en |-> (primed_reg && $past(mem_rd_en)))
        else $error("history write without a preceding read");

    // a full ring implies a primed filter
    assert property (@(posedge aclk) disable iff (!aresetn)
        full_reg |-> primed_reg)
        else $error("ring full while not primed");

    // a new result only appears from the done state
    assert property (@(posedge aclk) disable iff (!aresetn)
        (!m_valid_reg ##1 m_valid_reg) |-> $past(state_reg == ST_DONE))
        else $error("result beat without a finished item");
`endif

endmodule
